>>> design/mcq_pkg.sv
// ----------------------------------------------------------------------------
// mcq_pkg
// shared types and codes of the multi-channel drop-oldest frame queue
// ----------------------------------------------------------------------------
package mcq_pkg;

   localparam int HANDLE_W   = 16;
   localparam int CHAN_W     = 4;
   localparam int MIN_FILL_W = 5;
   localparam logic [MIN_FILL_W-1:0] MIN_FILL_RESET = 5'd5;

   // request kind
   typedef enum logic {
      MODE_PUSH = 1'b0,
      MODE_GET  = 1'b1
   } mode_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_PUSHED    = 3'd0,
      ST_DROPPED   = 3'd1,
      ST_PUSH_BAD  = 3'd2,
      ST_GOT       = 3'd3,
      ST_NOT_READY = 3'd4,
      ST_GET_BAD   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_EXEC
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_item;
      logic issue_read;
      logic execute;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_hold;
   } stat_type;

endpackage

>>> design/mcq_ram.sv
// ----------------------------------------------------------------------------
// mcq_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mcq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/mcq_ctrl.sv
// ----------------------------------------------------------------------------
// mcq_ctrl
// sequencer: take a beat, read the oldest slot, then update and respond
// ----------------------------------------------------------------------------
module mcq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  mcq_pkg::stat_type stat,
   output mcq_pkg::cmd_type  cmd
);

   mcq_pkg::state_type state_ff;
   mcq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mcq_pkg::S_IDLE: begin
            if (req_tvalid) state_in = mcq_pkg::S_LOOKUP;
         end
         mcq_pkg::S_LOOKUP: begin
            state_in = mcq_pkg::S_EXEC;
         end
         mcq_pkg::S_EXEC: begin
            // wait while the previous result is still unclaimed
            if (!stat.rsp_hold) state_in = mcq_pkg::S_IDLE;
         end
         default: begin
            state_in = mcq_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready     = 1'b0;
      cmd.load_item  = 1'b0;
      cmd.issue_read = 1'b0;
      cmd.execute    = 1'b0;
      case (state_ff)
         mcq_pkg::S_IDLE: begin
            req_tready    = 1'b1;
            cmd.load_item = req_tvalid;
         end
         mcq_pkg::S_LOOKUP: begin
            cmd.issue_read = 1'b1;
         end
         mcq_pkg::S_EXEC: begin
            cmd.execute = !stat.rsp_hold;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

>>> design/mcq_datapath.sv
// ----------------------------------------------------------------------------
// mcq_datapath
// per-channel fill and pointers, handle store, config and result register
// ----------------------------------------------------------------------------
module mcq_datapath #(
   parameter int CHANNELS = 8,
   parameter int DEPTH    = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mcq_pkg::cmd_type                   cmd,
   output mcq_pkg::stat_type                  stat,
   input  logic                               req_mode,
   input  logic [mcq_pkg::CHAN_W-1:0]         req_channel,
   input  logic [mcq_pkg::HANDLE_W-1:0]       req_handle,
   input  logic                               csr_wr_en,
   input  logic [mcq_pkg::MIN_FILL_W-1:0]     csr_wr_data,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [2:0]                         rsp_status,
   output logic [mcq_pkg::HANDLE_W-1:0]       rsp_handle,
   output logic                               rsp_handle_valid
);

   localparam int PTR_W  = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SLOTS  = CHANNELS * DEPTH;
   localparam int ADDR_W = $clog2(SLOTS);
   localparam int CMP_W  = (FILL_W > mcq_pkg::MIN_FILL_W) ? FILL_W : mcq_pkg::MIN_FILL_W;
   localparam int CHAN_W_P1 = mcq_pkg::CHAN_W + 1;

   localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);
   localparam logic [CHAN_W_P1-1:0] CH_LIMIT = CHAN_W_P1'(CHANNELS);

   // captured item
   logic                         mode_ff;
   logic [mcq_pkg::CHAN_W-1:0]   chan_ff;
   logic [mcq_pkg::HANDLE_W-1:0] handle_ff;

   logic [mcq_pkg::MIN_FILL_W-1:0] min_fill_ff;

   logic [FILL_W-1:0] fill_ff   [CHANNELS];
   logic [PTR_W-1:0]  rd_ptr_ff [CHANNELS];
   logic [PTR_W-1:0]  wr_ptr_ff [CHANNELS];
   logic [FILL_W-1:0] fill_in;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic              upd_en;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   mcq_pkg::status_type          rsp_status_ff;
   mcq_pkg::status_type          rsp_status_in;
   logic [mcq_pkg::HANDLE_W-1:0] rsp_handle_ff;
   logic [mcq_pkg::HANDLE_W-1:0] rsp_handle_in;
   logic                         rsp_hvalid_ff;
   logic                         rsp_hvalid_in;

   logic              ch_ok;
   logic [CH_W-1:0]   ch_idx;
   logic [FILL_W-1:0] cur_fill;
   logic [PTR_W-1:0]  cur_rd;
   logic [PTR_W-1:0]  cur_wr;
   logic [PTR_W-1:0]  rd_next;
   logic [PTR_W-1:0]  wr_next;
   logic              full;
   logic              starved;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              ram_we;
   logic [mcq_pkg::HANDLE_W-1:0] ram_q;

   assign ch_ok    = {1'b0, chan_ff} < CH_LIMIT;
   assign ch_idx   = CH_W'(chan_ff);
   assign cur_fill = fill_ff[ch_idx];
   assign cur_rd   = rd_ptr_ff[ch_idx];
   assign cur_wr   = wr_ptr_ff[ch_idx];
   assign rd_next  = (cur_rd == PTR_LAST) ? '0 : cur_rd + 1'b1;
   assign wr_next  = (cur_wr == PTR_LAST) ? '0 : cur_wr + 1'b1;
   assign full     = (cur_fill == FILL_FULL);
   // an empty channel never pops, even with min_fill of zero
   assign starved  = (cur_fill == '0) || (CMP_W'(cur_fill) < CMP_W'(min_fill_ff));

   // channel base is a multiply by a constant
   assign rd_addr = ADDR_W'(ch_idx * DEPTH) + ADDR_W'(cur_rd);
   assign wr_addr = ADDR_W'(ch_idx * DEPTH) + ADDR_W'(cur_wr);

   always_comb begin
      upd_en        = 1'b0;
      ram_we        = 1'b0;
      fill_in       = cur_fill;
      rd_ptr_in     = cur_rd;
      wr_ptr_in     = cur_wr;
      rsp_status_in = mcq_pkg::ST_PUSHED;
      rsp_handle_in = '0;
      rsp_hvalid_in = 1'b0;
      if (mode_ff == mcq_pkg::MODE_PUSH) begin
         if (!ch_ok) begin
            rsp_status_in = mcq_pkg::ST_PUSH_BAD;
            rsp_handle_in = handle_ff;
            rsp_hvalid_in = 1'b1;
         end else if (!full) begin
            upd_en    = cmd.execute;
            ram_we    = cmd.execute;
            wr_ptr_in = wr_next;
            fill_in   = cur_fill + 1'b1;
         end else begin
            // full: overwrite the oldest and hand it back
            upd_en        = cmd.execute;
            ram_we        = cmd.execute;
            wr_ptr_in     = wr_next;
            rd_ptr_in     = rd_next;
            rsp_status_in = mcq_pkg::ST_DROPPED;
            rsp_handle_in = ram_q;
            rsp_hvalid_in = 1'b1;
         end
      end else begin
         if (!ch_ok) begin
            rsp_status_in = mcq_pkg::ST_GET_BAD;
         end else if (starved) begin
            rsp_status_in = mcq_pkg::ST_NOT_READY;
         end else begin
            upd_en        = cmd.execute;
            rd_ptr_in     = rd_next;
            fill_in       = cur_fill - 1'b1;
            rsp_status_in = mcq_pkg::ST_GOT;
            rsp_handle_in = ram_q;
            rsp_hvalid_in = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign stat.rsp_hold = rsp_valid_ff && !rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_fill_ff  <= mcq_pkg::MIN_FILL_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            fill_ff[i]   <= '0;
            rd_ptr_ff[i] <= '0;
            wr_ptr_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            min_fill_ff <= csr_wr_data;
         end
         if (upd_en) begin
            fill_ff[ch_idx]   <= fill_in;
            rd_ptr_ff[ch_idx] <= rd_ptr_in;
            wr_ptr_ff[ch_idx] <= wr_ptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         mode_ff   <= req_mode;
         chan_ff   <= req_channel;
         handle_ff <= req_handle;
      end
      if (cmd.execute) begin
         rsp_status_ff <= rsp_status_in;
         rsp_handle_ff <= rsp_handle_in;
         rsp_hvalid_ff <= rsp_hvalid_in;
      end
   end

   mcq_ram #(
      .WIDTH (mcq_pkg::HANDLE_W),
      .DEPTH (SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data (handle_ff),
      .rd_en   (cmd.issue_read),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_handle       = rsp_handle_ff;
   assign rsp_handle_valid = rsp_hvalid_ff;

endmodule

>>> design/multi_channel_drop_oldest_frame_queue.sv
// ----------------------------------------------------------------------------
// multi_channel_drop_oldest_frame_queue
// per-channel frame handle queues that drop the oldest handle on overflow
// ----------------------------------------------------------------------------
// Each of CHANNELS queues holds up to DEPTH 16-bit frame handles. A push beat
// stores a handle; on a full channel the oldest handle is overwritten and
// returned so software can free it. A get beat pops the oldest handle once
// the channel holds at least min_fill handles (and at least one), else it
// answers not ready. Beats to a channel at or above CHANNELS come back as
// bad-channel results with no state change. Every request beat gives exactly
// one response beat. An item passes three steps from acceptance to its
// result (capture, registered read of the handle store, update). A finished
// result sits in an output register, so the next request is taken while it
// waits for rsp_tready. min_fill resets to 5; the user writes it through
// csr_wr_en only while the queue is idle, which the block does not enforce.
// The handle store has no reset: only handles of written slots are returned.
module multi_channel_drop_oldest_frame_queue #(
   parameter int CHANNELS = 8,
   parameter int DEPTH    = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [3:0] channel, [19:4] frame_handle, [23:20] zero
   input  logic [0:0]  req_tuser,   // [0] mode: push or get
   // response side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] handle_out
   output logic [3:0]  rsp_tuser,   // [2:0] status, [3] handle_valid
   // min_fill register
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data
);

   mcq_pkg::cmd_type  cmd;
   mcq_pkg::stat_type stat;
   logic [2:0]        rsp_status;
   logic              rsp_handle_valid;

   mcq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mcq_datapath #(
      .CHANNELS (CHANNELS),
      .DEPTH    (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_mode         (req_tuser[0]),
      .req_channel      (req_tdata[3:0]),
      .req_handle       (req_tdata[19:4]),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_status       (rsp_status),
      .rsp_handle       (rsp_tdata),
      .rsp_handle_valid (rsp_handle_valid)
   );

   // status and handle flag travel together in tuser
   assign rsp_tuser = {rsp_handle_valid, rsp_status};

endmodule
